### rtl/leh_pkg.sv
// Shared types, character codes and echo sequence tables for the line editor.
`timescale 1ns / 1ps

package leh_pkg;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_PROMPT = 8'h3e;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_K      = 8'h4b;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONST,
    S_COPY,
    S_RECALL
  } state_e;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SKIP,
    ESC_CODE
  } esc_e;

  typedef enum logic [1:0] {
    SEQ_ECHO,
    SEQ_BS,
    SEQ_NL,
    SEQ_CLEAR
  } seq_e;

  typedef logic [2:0] seq_idx_t;

  // Byte at position idx of a fixed echo sequence
  function automatic logic [7:0] seq_byte(seq_e kind, seq_idx_t idx, logic [7:0] echo);
    logic [7:0] b;
    b = echo;
    unique case (kind)
      SEQ_ECHO: b = echo;
      SEQ_BS:   b = (idx == seq_idx_t'(1)) ? CH_SP : CH_BS;
      SEQ_NL: begin
        if (idx == seq_idx_t'(0)) b = CH_LF;
        else if (idx == seq_idx_t'(1)) b = CH_PROMPT;
        else b = CH_SP;
      end
      SEQ_CLEAR: begin
        unique case (idx)
          seq_idx_t'(0): b = CH_ESC;
          seq_idx_t'(1): b = CH_LBRK;
          seq_idx_t'(2): b = CH_TWO;
          seq_idx_t'(3): b = CH_K;
          default:       b = CH_CR;
        endcase
      end
      default: b = echo;
    endcase
    return b;
  endfunction

  // Position of the final byte of a fixed echo sequence
  function automatic seq_idx_t seq_last(seq_e kind);
    seq_idx_t n;
    n = seq_idx_t'(0);
    unique case (kind)
      SEQ_ECHO:  n = seq_idx_t'(0);
      SEQ_BS:    n = seq_idx_t'(2);
      SEQ_NL:    n = seq_idx_t'(2);
      SEQ_CLEAR: n = seq_idx_t'(4);
      default:   n = seq_idx_t'(0);
    endcase
    return n;
  endfunction

endpackage

### rtl/line_editor_with_history.sv
// Line editor with echo generation and a ring of recently committed lines.
//
// Takes one keyboard byte per input item and emits the terminal echo as a run
// of output items, tlast on the final byte of each run. A printable byte,
// delete or escape byte is taken and its echo (zero to three bytes) leaves at
// one byte per cycle while the output is not stalled. A newline that commits a
// line first copies the edit line into the ring memory, one byte per cycle
// through its read port, then emits newline and prompt. A recall emits the
// five-byte clear sequence and then streams the stored line out of the ring
// memory at one byte per cycle while the output is not stalled, copying it
// into the edit line. One item is worked at a time; a new item is taken as soon
// as the last byte of the previous one sits in the output register. The stores
// need no clearing pass after reset.
`timescale 1ns / 1ps

module line_editor_with_history
  import leh_pkg::*;
#(
  parameter int LINE_LEN   = 32,
  parameter int RING_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  localparam int LEN_W  = $clog2(LINE_LEN);
  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int TW     = CNT_W + 1;
  localparam int RG_AW  = SLOT_W + LEN_W;
  localparam int RG_DEPTH = RING_DEPTH * (2 ** LEN_W);
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(LINE_LEN - 1);

  // Control and payload registers
  state_e             st_q, st_d;
  esc_e               esc_q, esc_d;
  logic [LEN_W-1:0]   edit_len_q, edit_len_d;
  logic [SLOT_W-1:0]  ws_q, ws_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   recall_q, recall_d;
  logic [SLOT_W-1:0]  rslot_q, rslot_d;
  logic [SLOT_W-1:0]  cp_slot_q, cp_slot_d;
  logic [LEN_W-1:0]   cp_len_q, cp_len_d;
  seq_e               seq_q, seq_d;
  seq_idx_t           sidx_q, sidx_d;
  logic [7:0]         echo_q, echo_d;
  logic [LEN_W-1:0]   rd_idx_q, rd_idx_d;
  logic [LEN_W-1:0]   wr_idx_q, wr_idx_d;
  logic               pend_q, pend_d;
  logic               m_valid_q, m_valid_d;
  logic [7:0]         m_data_q, m_data_d;
  logic               m_last_q, m_last_d;

  // Memories
  logic [7:0]         edit_mem [LINE_LEN];
  logic [7:0]         ring_mem [RG_DEPTH];
  logic [LEN_W-1:0]   ring_len_q [RING_DEPTH];

  logic               ed_we, ed_re;
  logic [LEN_W-1:0]   ed_waddr, ed_raddr;
  logic [7:0]         ed_wdata, ed_rdata_q;
  logic               rg_we, rg_re;
  logic [RG_AW-1:0]   rg_waddr, rg_raddr;
  logic [7:0]         rg_wdata, rg_rdata_q;
  logic               len_we;
  logic [SLOT_W-1:0]  len_wslot;
  logic [LEN_W-1:0]   len_wdata;

  logic               accept, out_free, is_end, move, issue, rec_ok;
  logic [7:0]         b;
  logic [CNT_W-1:0]   rp_new;
  logic [TW-1:0]      slot_sum;
  logic [SLOT_W-1:0]  rslot_new;

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign b        = s_axis_tdata_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // Slot of the k-th newest entry, k = recall position after the step
  always_comb begin
    rp_new   = (b == CH_UP) ? recall_q + CNT_W'(1) : recall_q - CNT_W'(1);
    slot_sum = TW'(ws_q) + TW'(RING_DEPTH) - TW'(rp_new);
    if (slot_sum >= TW'(RING_DEPTH)) begin
      slot_sum = slot_sum - TW'(RING_DEPTH);
    end
    rslot_new = slot_sum[SLOT_W-1:0];
    rec_ok = (b == CH_UP && recall_q < used_q) ||
             (b == CH_DOWN && recall_q > CNT_W'(1));
  end

  always_comb begin
    st_d       = st_q;
    esc_d      = esc_q;
    edit_len_d = edit_len_q;
    ws_d       = ws_q;
    used_d     = used_q;
    recall_d   = recall_q;
    rslot_d    = rslot_q;
    cp_slot_d  = cp_slot_q;
    cp_len_d   = cp_len_q;
    seq_d      = seq_q;
    sidx_d     = sidx_q;
    echo_d     = echo_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    pend_d     = pend_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    ed_we      = 1'b0;
    ed_waddr   = edit_len_q;
    ed_wdata   = b;
    ed_re      = 1'b0;
    ed_raddr   = rd_idx_q;
    rg_we      = 1'b0;
    rg_waddr   = {cp_slot_q, wr_idx_q};
    rg_wdata   = ed_rdata_q;
    rg_re      = 1'b0;
    rg_raddr   = {rslot_q, rd_idx_q};
    len_we     = 1'b0;
    len_wslot  = ws_q;
    len_wdata  = edit_len_q;
    is_end     = 1'b0;
    move       = 1'b0;
    issue      = 1'b0;

    // Output register empties when taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          unique case (esc_q)
            ESC_SKIP: esc_d = ESC_CODE;
            ESC_CODE: begin
              esc_d = ESC_IDLE;
              if (rec_ok) begin
                recall_d   = rp_new;
                rslot_d    = rslot_new;
                edit_len_d = ring_len_q[rslot_new];
                seq_d      = SEQ_CLEAR;
                sidx_d     = seq_idx_t'(0);
                st_d       = S_CONST;
              end
            end
            default: begin
              if (b == CH_ESC) begin
                esc_d = ESC_SKIP;
              end else if (b == CH_LF) begin
                seq_d      = SEQ_NL;
                sidx_d     = seq_idx_t'(0);
                edit_len_d = '0;
                if (edit_len_q != '0) begin
                  // Commit: book the slot now, copy the bytes next
                  cp_slot_d = ws_q;
                  cp_len_d  = edit_len_q;
                  len_we    = 1'b1;
                  ws_d      = (ws_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : ws_q + SLOT_W'(1);
                  if (used_q != CNT_W'(RING_DEPTH)) begin
                    used_d = used_q + CNT_W'(1);
                  end
                  recall_d = '0;
                  rd_idx_d = '0;
                  pend_d   = 1'b0;
                  st_d     = S_COPY;
                end else begin
                  st_d = S_CONST;
                end
              end else if (b == CH_DEL) begin
                if (edit_len_q != '0) begin
                  edit_len_d = edit_len_q - LEN_W'(1);
                  seq_d      = SEQ_BS;
                  sidx_d     = seq_idx_t'(0);
                  st_d       = S_CONST;
                end
              end else if (b >= CH_SP && b <= CH_TILDE) begin
                if (edit_len_q < LenMax) begin
                  ed_we      = 1'b1;
                  edit_len_d = edit_len_q + LEN_W'(1);
                  echo_d     = b;
                  seq_d      = SEQ_ECHO;
                  sidx_d     = seq_idx_t'(0);
                  st_d       = S_CONST;
                end
              end
            end
          endcase
        end
      end

      S_CONST: begin
        if (out_free) begin
          is_end    = (sidx_q == seq_last(seq_q));
          m_valid_d = 1'b1;
          m_data_d  = seq_byte(seq_q, sidx_q, echo_q);
          m_last_d  = is_end && !(seq_q == SEQ_CLEAR && edit_len_q != '0);
          sidx_d    = sidx_q + seq_idx_t'(1);
          if (is_end) begin
            if (seq_q == SEQ_CLEAR && edit_len_q != '0) begin
              rd_idx_d = '0;
              pend_d   = 1'b0;
              st_d     = S_RECALL;
            end else begin
              st_d = S_IDLE;
            end
          end
        end
      end

      S_COPY: begin
        // Read edit line, write ring in the following cycle
        if (pend_q) begin
          rg_we = 1'b1;
        end
        issue = (rd_idx_q < cp_len_q);
        if (issue) begin
          ed_re    = 1'b1;
          wr_idx_d = rd_idx_q;
          rd_idx_d = rd_idx_q + LEN_W'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && wr_idx_q == cp_len_q - LEN_W'(1)) begin
          st_d = S_CONST;
        end
      end

      S_RECALL: begin
        // Stream ring entry out; hold read data while the output stalls
        move = pend_q && out_free;
        if (move) begin
          is_end    = (wr_idx_q == edit_len_q - LEN_W'(1));
          m_valid_d = 1'b1;
          m_data_d  = rg_rdata_q;
          m_last_d  = is_end;
          ed_we     = 1'b1;
          ed_waddr  = wr_idx_q;
          ed_wdata  = rg_rdata_q;
        end
        issue = (rd_idx_q < edit_len_q) && (!pend_q || move);
        if (issue) begin
          rg_re    = 1'b1;
          wr_idx_d = rd_idx_q;
          rd_idx_d = rd_idx_q + LEN_W'(1);
          pend_d   = 1'b1;
        end else if (move) begin
          pend_d = 1'b0;
        end
        if (move && is_end) begin
          st_d = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      esc_q      <= ESC_IDLE;
      edit_len_q <= '0;
      ws_q       <= '0;
      used_q     <= '0;
      recall_q   <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      esc_q      <= esc_d;
      edit_len_q <= edit_len_d;
      ws_q       <= ws_d;
      used_q     <= used_d;
      recall_q   <= recall_d;
      pend_q     <= pend_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q   <= rslot_d;
    cp_slot_q <= cp_slot_d;
    cp_len_q  <= cp_len_d;
    seq_q     <= seq_d;
    sidx_q    <= sidx_d;
    echo_q    <= echo_d;
    rd_idx_q  <= rd_idx_d;
    wr_idx_q  <= wr_idx_d;
    m_data_q  <= m_data_d;
    m_last_q  <= m_last_d;
  end

  // Edit line memory
  always_ff @(posedge clk_i) begin
    if (ed_we) begin
      edit_mem[ed_waddr] <= ed_wdata;
    end
    if (ed_re) begin
      ed_rdata_q <= edit_mem[ed_raddr];
    end
  end

  // Ring line memory
  always_ff @(posedge clk_i) begin
    if (rg_we) begin
      ring_mem[rg_waddr] <= rg_wdata;
    end
    if (rg_re) begin
      rg_rdata_q <= ring_mem[rg_raddr];
    end
  end

  // Ring entry lengths
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      ring_len_q[len_wslot] <= len_wdata;
    end
  end

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_recall_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    recall_q <= used_q)
    else $error("recall position beyond filled entries");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    edit_len_q <= LenMax)
    else $error("edit length beyond line capacity");

  a_pend_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (st_q == S_COPY || st_q == S_RECALL))
    else $error("memory read pending outside a copy");

  a_recall_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RECALL && pend_q && m_valid_q && !m_axis_tready_i) |=>
      (pend_q && $stable(rg_rdata_q)))
    else $error("recall read data lost under stall");

endmodule
